// ===== sv/hhdm_pkg.sv =====
// hhdm_pkg: widths, constants and register codes of the heading hold mixer
// used by the channel interfaces and by the top level; no dependencies
`timescale 1ns / 1ps

package hhdm_pkg;

  // stick, heading and pulse field widths
  localparam int STICK_W = 12;
  localparam int YAW_W   = 9;
  localparam int PULSE_W = 11;

  // configuration register widths
  localparam int GAIN_W     = 6;
  localparam int DEADBAND_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // register reset values
  localparam logic [GAIN_W-1:0]     GAIN_RST     = 6'd15;
  localparam logic [STICK_W-1:0]    ENGAGE_RST   = 12'd1930;
  localparam logic [STICK_W-1:0]    RELEASE_RST  = 12'd1070;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 9'd30;

  // arithmetic constants
  localparam logic signed [12:0] STICK_CENTRE = 13'sd1500;
  localparam logic signed [10:0] HALF_TURN    = 11'sd180;
  localparam logic signed [10:0] FULL_TURN    = 11'sd360;
  localparam logic signed [18:0] MIX_LIMIT    = 19'sd500;
  localparam logic [PULSE_W-1:0] PULSE_BASE   = 11'd1000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN     = 2'd0,
    REG_ENGAGE   = 2'd1,
    REG_RELEASE  = 2'd2,
    REG_DEADBAND = 2'd3
  } cfg_reg_t;

endpackage

// ===== sv/hhdm_in_if.sv =====
// hhdm_in_if: stick and yaw input channel, valid/ready handshake
// depends on hhdm_pkg
`timescale 1ns / 1ps

interface hhdm_in_if;
  logic                                valid;
  logic                                ready;
  logic [hhdm_pkg::STICK_W-1:0]        pitch_stick;
  logic [hhdm_pkg::STICK_W-1:0]        roll_stick;
  logic [hhdm_pkg::STICK_W-1:0]        throttle_stick;
  logic signed [hhdm_pkg::YAW_W-1:0]   yaw_degrees;

  modport source (output valid, pitch_stick, roll_stick, throttle_stick, yaw_degrees,
                  input ready);
  modport sink   (input valid, pitch_stick, roll_stick, throttle_stick, yaw_degrees,
                  output ready);
endinterface

// ===== sv/hhdm_out_if.sv =====
// hhdm_out_if: motor command result channel, valid/ready handshake
// depends on hhdm_pkg
`timescale 1ns / 1ps

interface hhdm_out_if;
  logic                         valid;
  logic                         ready;
  logic [hhdm_pkg::PULSE_W-1:0] left_pulse;
  logic                         left_backward;
  logic [hhdm_pkg::PULSE_W-1:0] right_pulse;
  logic                         right_backward;
  logic                         hold_engaged;

  modport source (output valid, left_pulse, left_backward, right_pulse, right_backward,
                  hold_engaged, input ready);
  modport sink   (input valid, left_pulse, left_backward, right_pulse, right_backward,
                  hold_engaged, output ready);
endinterface

// ===== sv/hhdm_cfg_if.sv =====
// hhdm_cfg_if: configuration write channel, register index and data
// depends on hhdm_pkg
`timescale 1ns / 1ps

interface hhdm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hhdm_pkg::CFG_IDX_W-1:0]  index;
  logic [hhdm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/heading_hold_differential_drive_mixer.sv =====
// heading_hold_differential_drive_mixer: hold mode, heading steer and motor mix
// depends on hhdm_pkg, hhdm_in_if, hhdm_out_if, hhdm_cfg_if
//
//   channel   direction  word
//   in_ch     sink       pitch, roll, throttle stick, yaw degrees
//   out_ch    source     left/right pulse and backward bit, hold engaged
//   cfg_ch    sink       register index, write data (always ready)
//
// one word per cycle sustained while out_ch takes words; from in_ch to out_ch a word passes
// through the input register, then mix logic into the output register
// hold mode and target heading update as a word moves into the output register
// rst_n is synchronous: clears valids, hold mode, target and loads register defaults
// a stalled output keeps its word; the input register still takes one more word
`timescale 1ns / 1ps

module heading_hold_differential_drive_mixer (
  input  logic       clk,
  input  logic       rst_n,
  hhdm_in_if.sink    in_ch,
  hhdm_out_if.source out_ch,
  hhdm_cfg_if.sink   cfg_ch
);

  // configuration registers
  logic [hhdm_pkg::GAIN_W-1:0]     gain_r;
  logic [hhdm_pkg::STICK_W-1:0]    engage_r;
  logic [hhdm_pkg::STICK_W-1:0]    release_r;
  logic [hhdm_pkg::DEADBAND_W-1:0] deadband_r;

  // input register
  logic                              in_valid_r;
  logic [hhdm_pkg::STICK_W-1:0]      pitch_r;
  logic [hhdm_pkg::STICK_W-1:0]      roll_r;
  logic [hhdm_pkg::STICK_W-1:0]      throttle_r;
  logic signed [hhdm_pkg::YAW_W-1:0] yaw_r;

  // mode state
  logic                              hold_r, hold_nxt;
  logic signed [hhdm_pkg::YAW_W-1:0] target_r, target_nxt;

  // output register
  logic                         out_valid_r;
  logic [hhdm_pkg::PULSE_W-1:0] left_pulse_r, left_pulse_nxt;
  logic                         left_back_r, left_back_nxt;
  logic [hhdm_pkg::PULSE_W-1:0] right_pulse_r, right_pulse_nxt;
  logic                         right_back_r, right_back_nxt;
  logic                         hold_out_r;

  // handshake
  logic out_free;
  logic advance;

  // datapath
  logic                              engage_hit;
  logic signed [hhdm_pkg::YAW_W-1:0] target_mid;
  logic signed [12:0]                roll_dev, roll_neg, thr_dev;
  logic [11:0]                       roll_abs;
  logic                              auto_steer;
  logic signed [9:0]                 err_raw;
  logic signed [10:0]                err_ext, err_wrap;
  logic signed [17:0]                prod, steer_dev, half;
  logic signed [18:0]                left_sum, right_sum;
  logic signed [9:0]                 left_mix, right_mix;

  function automatic logic signed [9:0] sat_mix(input logic signed [18:0] v);
    logic signed [9:0] r;
    r = v[9:0];
    if (v > hhdm_pkg::MIX_LIMIT) begin
      r = 10'sd500;
    end else if (v < -hhdm_pkg::MIX_LIMIT) begin
      r = -10'sd500;
    end
    return r;
  endfunction

  function automatic logic [hhdm_pkg::PULSE_W-1:0] pulse_of(input logic signed [9:0] m);
    logic signed [9:0] neg;
    logic [8:0]        mag;
    neg = -m;
    mag = m[9] ? neg[8:0] : m[8:0];
    return hhdm_pkg::PULSE_BASE + {1'b0, mag, 1'b0};
  endfunction

  // handshake: output frees when empty or taken, input moves when output frees
  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= hhdm_pkg::GAIN_RST;
      engage_r   <= hhdm_pkg::ENGAGE_RST;
      release_r  <= hhdm_pkg::RELEASE_RST;
      deadband_r <= hhdm_pkg::DEADBAND_RST;
    end else if (cfg_ch.valid) begin
      unique case (hhdm_pkg::cfg_reg_t'(cfg_ch.index))
        hhdm_pkg::REG_GAIN:     gain_r     <= cfg_ch.data[hhdm_pkg::GAIN_W-1:0];
        hhdm_pkg::REG_ENGAGE:   engage_r   <= cfg_ch.data[hhdm_pkg::STICK_W-1:0];
        hhdm_pkg::REG_RELEASE:  release_r  <= cfg_ch.data[hhdm_pkg::STICK_W-1:0];
        hhdm_pkg::REG_DEADBAND: deadband_r <= cfg_ch.data[hhdm_pkg::DEADBAND_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      pitch_r    <= in_ch.pitch_stick;
      roll_r     <= in_ch.roll_stick;
      throttle_r <= in_ch.throttle_stick;
      yaw_r      <= in_ch.yaw_degrees;
    end
  end

  // hold mode: engaging wins over releasing
  always_comb begin
    engage_hit = pitch_r >= engage_r;
    hold_nxt   = hold_r;
    if (engage_hit) begin
      hold_nxt = 1'b1;
    end else if (pitch_r < release_r) begin
      hold_nxt = 1'b0;
    end
    target_mid = engage_hit ? yaw_r : target_r;
  end

  // roll distance from centre and automatic steer select
  always_comb begin
    roll_dev   = $signed({1'b0, roll_r}) - hhdm_pkg::STICK_CENTRE;
    roll_neg   = -roll_dev;
    roll_abs   = roll_dev[12] ? roll_neg[11:0] : roll_dev[11:0];
    auto_steer = hold_nxt && (roll_abs < {3'b000, deadband_r});
    target_nxt = (hold_nxt && !auto_steer) ? yaw_r : target_mid;
  end

  // heading error, one wrap step, gain
  always_comb begin
    err_raw  = {target_mid[8], target_mid} - {yaw_r[8], yaw_r};
    err_ext  = {err_raw[9], err_raw};
    err_wrap = err_ext;
    if (err_ext > hhdm_pkg::HALF_TURN) begin
      err_wrap = err_ext - hhdm_pkg::FULL_TURN;
    end else if (err_ext < -hhdm_pkg::HALF_TURN) begin
      err_wrap = err_ext + hhdm_pkg::FULL_TURN;
    end
    prod = $signed({1'b0, gain_r}) * err_wrap;
  end

  // steer halving toward zero and motor mix
  always_comb begin
    steer_dev = auto_steer ? prod : {{5{roll_dev[12]}}, roll_dev};
    half      = (steer_dev + $signed({17'd0, steer_dev[17]})) >>> 1;
    thr_dev   = $signed({1'b0, throttle_r}) - hhdm_pkg::STICK_CENTRE;
    left_sum  = {{6{thr_dev[12]}}, thr_dev} + {half[17], half};
    right_sum = {{6{thr_dev[12]}}, thr_dev} - {half[17], half};
    left_mix  = sat_mix(left_sum);
    right_mix = sat_mix(right_sum);
    left_pulse_nxt  = pulse_of(left_mix);
    left_back_nxt   = !left_mix[9];
    right_pulse_nxt = pulse_of(right_mix);
    right_back_nxt  = right_mix[9];
  end

  // mode state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= 1'b0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        hold_r   <= hold_nxt;
        target_r <= target_nxt;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      left_pulse_r  <= left_pulse_nxt;
      left_back_r   <= left_back_nxt;
      right_pulse_r <= right_pulse_nxt;
      right_back_r  <= right_back_nxt;
      hold_out_r    <= hold_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_pulse     = left_pulse_r;
  assign out_ch.left_backward  = left_back_r;
  assign out_ch.right_pulse    = right_pulse_r;
  assign out_ch.right_backward = right_back_r;
  assign out_ch.hold_engaged   = hold_out_r;

  // shown hold flag matches the stored mode
  a_hold_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (hold_out_r == hold_r))
    else $error("hold_engaged differs from stored hold mode");

  // pulses stay within the saturated range
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (left_pulse_r >= 11'd1000 && left_pulse_r <= 11'd2000 &&
                     right_pulse_r >= 11'd1000 && right_pulse_r <= 11'd2000))
    else $error("motor pulse out of range");

  // a zero mix drives left backward and right forward
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (left_pulse_r == hhdm_pkg::PULSE_BASE) |-> left_back_r)
    else $error("left direction wrong for zero mix");

  a_zero_dir_r: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (right_pulse_r == hhdm_pkg::PULSE_BASE) |-> !right_back_r)
    else $error("right direction wrong for zero mix");

  // a word in the input register is not dropped while the output stalls
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r && $stable(pitch_r) && $stable(yaw_r))
    else $error("input word lost under stall");

endmodule

// ===== tb/heading_hold_differential_drive_mixer_tb.sv =====
// heading_hold_differential_drive_mixer_tb: checks hold mode, heading steer and motor mix
// against an in-bench predictor; directed ticks, then random phases under several register
// settings; depends on hhdm_pkg, the three channel interfaces and the mixer top level
`timescale 1ns / 1ps

module heading_hold_differential_drive_mixer_tb;

  localparam int CLK_PERIOD    = 10;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_TICKS   = 130;
  localparam int HOLD_OFF_LEN  = 300;

  // integer views of the package constants for the predictor
  localparam int CENTRE = hhdm_pkg::STICK_CENTRE;
  localparam int HALF   = hhdm_pkg::HALF_TURN;
  localparam int FULL   = hhdm_pkg::FULL_TURN;
  localparam int LIMIT  = hhdm_pkg::MIX_LIMIT;
  localparam int BASE   = hhdm_pkg::PULSE_BASE;

  typedef struct {
    logic [hhdm_pkg::STICK_W-1:0]      pitch;
    logic [hhdm_pkg::STICK_W-1:0]      roll;
    logic [hhdm_pkg::STICK_W-1:0]      throttle;
    logic signed [hhdm_pkg::YAW_W-1:0] yaw;
  } stick_word_t;

  typedef struct {
    logic [hhdm_pkg::PULSE_W-1:0] left_pulse;
    logic                         left_backward;
    logic [hhdm_pkg::PULSE_W-1:0] right_pulse;
    logic                         right_backward;
    logic                         hold_engaged;
  } motor_word_t;

  logic clk;
  logic rst_n;

  hhdm_in_if  in_ch ();
  hhdm_out_if out_ch ();
  hhdm_cfg_if cfg_ch ();

  heading_hold_differential_drive_mixer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // register shadows and mixer state of the predictor
  int   gain_cfg     = hhdm_pkg::GAIN_RST;
  int   engage_thr   = hhdm_pkg::ENGAGE_RST;
  int   release_thr  = hhdm_pkg::RELEASE_RST;
  int   deadband_cfg = hhdm_pkg::DEADBAND_RST;
  logic hold_on      = 1'b0;
  int   target_deg   = 0;

  stick_word_t stick_feed[$];
  motor_word_t motor_expect[$];
  stick_word_t on_offer;

  int   mismatches = 0;
  int   cycle_count = 0;
  int   yaw_track = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   hold_off_left = 0;
  logic hold_off_armed = 1'b0;
  int   mode_left = 0;
  int   ready_mode = 0;
  logic [15:0] stall_pattern = 16'hffff;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int clamp_mix(int v);
    if (v < -LIMIT) return -LIMIT;
    if (v > LIMIT) return LIMIT;
    return v;
  endfunction

  // predicted motor word for one tick; updates hold mode and target heading
  function automatic motor_word_t mix_sticks(stick_word_t w);
    int pitch, roll, throttle, yaw, dev, err, steer, half_steer, left, right;
    motor_word_t m;
    pitch    = w.pitch;
    roll     = w.roll;
    throttle = w.throttle;
    yaw      = $signed(w.yaw);
    // engage wins when both threshold conditions hold
    if (pitch >= engage_thr) begin
      hold_on    = 1'b1;
      target_deg = yaw;
    end else if (pitch < release_thr) begin
      hold_on = 1'b0;
    end
    dev = roll - CENTRE;
    if (dev < 0) dev = -dev;
    if (hold_on && dev < deadband_cfg) begin
      // single wrap step only
      err = target_deg - yaw;
      if (err > HALF) err -= FULL;
      else if (err < -HALF) err += FULL;
      steer = CENTRE + gain_cfg * err;
    end else begin
      steer = roll;
      if (hold_on) target_deg = yaw;
    end
    half_steer = (steer - CENTRE) / 2;
    left  = clamp_mix(throttle - CENTRE + half_steer);
    right = clamp_mix(throttle - CENTRE - half_steer);
    m.left_pulse     = hhdm_pkg::PULSE_W'(BASE + 2 * (left < 0 ? -left : left));
    m.left_backward  = (left >= 0);
    m.right_pulse    = hhdm_pkg::PULSE_W'(BASE + 2 * (right < 0 ? -right : right));
    m.right_backward = (right < 0);
    m.hold_engaged   = hold_on;
    return m;
  endfunction

  function automatic stick_word_t sticks(int p, int r, int t, int y);
    stick_word_t w;
    w.pitch    = hhdm_pkg::STICK_W'(p);
    w.roll     = hhdm_pkg::STICK_W'(r);
    w.throttle = hhdm_pkg::STICK_W'(t);
    w.yaw      = hhdm_pkg::YAW_W'(y);
    return w;
  endfunction

  // random tick, mostly hold sequences around the current thresholds
  function automatic stick_word_t random_sticks();
    int p, r, t, off, pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      p = engage_thr + $urandom_range(0, 200);
      if (p > 4095) p = 4095;
    end else if (pick < 18) begin
      p = release_thr - int'($urandom_range(1, 200));
      if (p < 0) p = 0;
    end else if (pick < 23) begin
      p = $urandom_range(0, 4095);
    end else if (release_thr < engage_thr) begin
      p = $urandom_range(release_thr, engage_thr - 1);
    end else begin
      p = $urandom_range(800, 2200);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      off = $urandom_range(0, deadband_cfg);
      r = $urandom_range(0, 1) ? CENTRE + off : CENTRE - off;
    end else if (pick < 85) begin
      r = $urandom_range(800, 2200);
    end else begin
      r = $urandom_range(0, 4095);
    end
    t = ($urandom_range(0, 99) < 85) ? $urandom_range(800, 2200) : $urandom_range(0, 4095);
    // heading drifts, with the odd jump over the whole field
    if ($urandom_range(0, 99) < 8) begin
      yaw_track = int'($urandom_range(0, 511)) - 256;
    end else begin
      yaw_track += int'($urandom_range(0, 20)) - 10;
      if (yaw_track > HALF) yaw_track -= FULL;
      else if (yaw_track < -HALF) yaw_track += FULL;
    end
    return sticks(p, r, t, yaw_track);
  endfunction

  task automatic compare_field(string name, logic [hhdm_pkg::PULSE_W-1:0] want,
                               logic [hhdm_pkg::PULSE_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // sender: bursts of words with random gaps, predicting each accepted word
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) motor_expect.push_back(mix_sticks(on_offer));
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (stick_feed.size() != 0) begin
        on_offer = stick_feed.pop_front();
        in_ch.pitch_stick    <= on_offer.pitch;
        in_ch.roll_stick     <= on_offer.roll;
        in_ch.throttle_stick <= on_offer.throttle;
        in_ch.yaw_degrees    <= on_offer.yaw;
        in_ch.valid          <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: checks each word, stalls on its own pattern, one long hold-off on request
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (motor_expect.size() == 0) begin
        $error("motor word with no expectation pending");
        mismatches++;
      end else begin
        motor_word_t want;
        want = motor_expect.pop_front();
        compare_field("left_pulse", want.left_pulse, out_ch.left_pulse);
        compare_field("left_backward", want.left_backward, out_ch.left_backward);
        compare_field("right_pulse", want.right_pulse, out_ch.right_pulse);
        compare_field("right_backward", want.right_backward, out_ch.right_backward);
        compare_field("hold_engaged", want.hold_engaged, out_ch.hold_engaged);
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_left--;
    end else if (hold_off_armed) begin
      hold_off_armed <= 1'b0;
      hold_off_left = HOLD_OFF_LEN;
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left     = 64;
        ready_mode    = $urandom_range(0, 2);
        stall_pattern = $urandom;
      end
      mode_left--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= stall_pattern[0];
        default: out_ch.ready <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  task automatic write_reg(hhdm_pkg::cfg_reg_t idx, logic [hhdm_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      hhdm_pkg::REG_GAIN:     gain_cfg     = value[hhdm_pkg::GAIN_W-1:0];
      hhdm_pkg::REG_ENGAGE:   engage_thr   = value;
      hhdm_pkg::REG_RELEASE:  release_thr  = value;
      hhdm_pkg::REG_DEADBAND: deadband_cfg = value[hhdm_pkg::DEADBAND_W-1:0];
    endcase
  endtask

  // unused upper data bits are random
  task automatic set_config(int g, int e, int r, int d);
    write_reg(hhdm_pkg::REG_GAIN, {6'($urandom), 6'(g)});
    write_reg(hhdm_pkg::REG_ENGAGE, 12'(e));
    write_reg(hhdm_pkg::REG_RELEASE, 12'(r));
    write_reg(hhdm_pkg::REG_DEADBAND, {3'($urandom), 9'(d)});
  endtask

  // sender idle until every predicted word has come back, then the pipeline settles;
  // sampled mid-cycle so that the edge's updates have all landed
  task automatic wait_drain();
    while (stick_feed.size() != 0 || in_ch.valid || motor_expect.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_tick(int p, int r, int t, int y);
    stick_feed.push_back(sticks(p, r, t, y));
  endtask

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.pitch_stick    = '0;
    in_ch.roll_stick     = '0;
    in_ch.throttle_stick = '0;
    in_ch.yaw_degrees    = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = hhdm_pkg::REG_GAIN;
    cfg_ch.data          = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed ticks at reset settings
    queue_tick(1500, 1500, 1500, 0);      // hold off, zero mix
    queue_tick(2200, 1500, 1500, 0);      // engage, target captured
    queue_tick(1500, 1500, 1500, 20);     // hold kept, heading error steers
    queue_tick(1500, 1510, 1600, -30);
    queue_tick(1500, 1700, 1500, 45);     // roll outside deadband, target recaptured
    queue_tick(1500, 1500, 1500, 45);
    queue_tick(2000, 1500, 1500, 170);    // error wraps across the half turn
    queue_tick(1500, 1500, 1500, -170);
    queue_tick(2000, 1500, 1500, -170);
    queue_tick(1500, 1500, 1500, 170);
    queue_tick(4095, 1500, 1500, 255);    // out-of-range yaw, one wrap step brings the error within half turn
    queue_tick(1500, 1500, 1500, -256);
    queue_tick(4095, 1500, 1500, -256);
    queue_tick(1500, 1500, 1500, 255);
    queue_tick(1070, 1500, 1500, 0);      // at release threshold, hold kept
    queue_tick(1069, 1500, 1500, 0);      // just below, hold released
    queue_tick(1930, 1501, 1500, 0);      // engage exactly at threshold
    queue_tick(1500, 1529, 1500, 10);     // just inside deadband
    queue_tick(1500, 1530, 1500, 10);     // on deadband edge, manual steer
    queue_tick(0, 1501, 1500, 0);         // halving truncates toward zero
    queue_tick(0, 1499, 1500, 0);
    queue_tick(0, 1497, 1500, 0);
    queue_tick(0, 2200, 2200, 0);         // mix saturation
    queue_tick(0, 800, 800, 0);
    queue_tick(0, 4095, 4095, 0);
    queue_tick(0, 0, 0, -1);
    queue_tick(1500, 1500, 1499, 0);      // smallest negative mix
    wait_drain();

    // random phases: extremes, crossed thresholds, then random settings
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0: set_config(63, 4095, 0, 511);
        1: set_config(0, 0, 4095, 0);
        2: set_config(31, 1200, 1800, 100);
        default: set_config($urandom_range(0, 63), $urandom_range(1500, 2200),
                            $urandom_range(800, 1500), $urandom_range(0, 200));
      endcase
      for (int i = 0; i < PHASE_TICKS; i++) stick_feed.push_back(random_sticks());
      if (k == 2) begin
        @(posedge clk);
        hold_off_armed <= 1'b1;
      end
      wait_drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
